>>> rtl/i2cram_pkg.sv
`timescale 1ns / 1ps

package i2cram_pkg;

    // operation codes on the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // phase encoding: {segment, sub-phase}, idle is the all-ones code
    localparam logic [5:0]  PH_IDLE      = 6'd63;
    localparam logic [2:0]  BIT_FIRST    = 3'd7;
    localparam logic [15:0] SETTLE_RESET = 16'd10000;

    // kind of line activity a segment performs
    typedef enum logic [3:0] {
        K_START  = 4'd0,
        K_DEV    = 4'd1,
        K_REG    = 4'd2,
        K_DATA   = 4'd3,
        K_DEVR   = 4'd4,
        K_ACK    = 4'd5,
        K_READ   = 4'd6,
        K_NOACK  = 4'd7,
        K_STOP   = 4'd8,
        K_SETTLE = 4'd9
    } t_kind;

    // one tick worth of input
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       line_in;
    } t_tick;

    // one tick worth of result
    typedef struct packed {
        logic       clock_line;
        logic       data_line;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_result;

    // segment sequence of a register write and of a register read
    function automatic t_kind kind_of(input logic [3:0] seg, input logic is_read);
        t_kind k;
        k = K_SETTLE;
        if (is_read) begin
            unique case (seg)
                4'd0:    k = K_START;
                4'd1:    k = K_DEV;
                4'd2:    k = K_ACK;
                4'd3:    k = K_REG;
                4'd4:    k = K_ACK;
                4'd5:    k = K_START;
                4'd6:    k = K_DEVR;
                4'd7:    k = K_ACK;
                4'd8:    k = K_READ;
                4'd9:    k = K_NOACK;
                4'd10:   k = K_STOP;
                default: k = K_SETTLE;
            endcase
        end else begin
            unique case (seg)
                4'd0:    k = K_START;
                4'd1:    k = K_DEV;
                4'd2:    k = K_ACK;
                4'd3:    k = K_REG;
                4'd4:    k = K_ACK;
                4'd5:    k = K_DATA;
                4'd6:    k = K_ACK;
                4'd7:    k = K_STOP;
                default: k = K_SETTLE;
            endcase
        end
        return k;
    endfunction

endpackage

>>> rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps

// I2C register access master. Each item on the input channel is one line-phase
// tick; it produces exactly one result item carrying the clock and data line
// levels for that tick, busy and done status, and the last byte read. An item
// is accepted every clock cycle as long as the output register is free or is
// being emptied in the same cycle, so the sustained rate is one tick per clock
// through the result register. An operation code of write or read given while
// idle latches the operands and drives the first line phase on that same tick;
// operations seen while busy are ignored. The settle_ticks register sets how
// many busy ticks follow the stop of a write. The user must write it through
// its own channel only while the block is idle; the block does not enforce it.
module i2c_register_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input ticks
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_device_address,
    input  logic [7:0]  i_register_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_line_in,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_clock_line,
    output logic        o_data_line,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    // settle_ticks register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import i2cram_pkg::*;

    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_settle_ticks;
    logic        in_accept;
    t_tick       tick;
    t_result     step_result;

    // accept a tick whenever the result register can take its result
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign tick.operation        = i_operation;
    assign tick.device_address   = i_device_address;
    assign tick.register_address = i_register_address;
    assign tick.write_data       = i_write_data;
    assign tick.line_in          = i_line_in;

    i2cram_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_accept),
        .i_tick         (tick),
        .i_settle_ticks (r_settle_ticks),
        .o_result       (step_result)
    );

    // settle length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
        end else if (i_cfg_valid) begin
            r_settle_ticks <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_clock_line = r_out.clock_line;
    assign o_data_line  = r_out.data_line;
    assign o_busy_res   = r_out.busy_res;
    assign o_done_res   = r_out.done_res;
    assign o_read_data  = r_out.read_data;

`ifndef SYNTH
    // done and busy never show together
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done result while busy");

    // a pending result that is not taken blocks the next tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !in_accept)
        else $error("result register overwritten before it was taken");

    // a done pulse lasts a single result
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && step_result.done_res) |=> !(in_accept && step_result.done_res))
        else $error("done held for more than one tick");
`endif

endmodule

>>> rtl/i2cram_core.sv
`timescale 1ns / 1ps

module i2cram_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  i2cram_pkg::t_tick    i_tick,
    input  logic [15:0]          i_settle_ticks,
    output i2cram_pkg::t_result  o_result
);
    import i2cram_pkg::*;

    logic [5:0]  r_phase, n_phase;
    logic [2:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift_byte, n_shift_byte;
    logic [7:0]  r_held_device, n_held_device;
    logic [7:0]  r_held_register, n_held_register;
    logic [7:0]  r_held_data, n_held_data;
    logic        r_is_read, n_is_read;
    logic [15:0] r_settle_count, n_settle_count;
    logic [7:0]  r_last_read, n_last_read;

    logic        start_op;
    logic [5:0]  a_phase;
    logic [2:0]  a_bit_count;
    logic [3:0]  seg;
    logic [1:0]  sub;
    logic [3:0]  nxt_seg;
    t_kind       kind;
    t_kind       nxt_kind;
    logic        do_enter;

    // a new transaction is latched while idle, and its first phase runs this tick
    assign start_op = (r_phase == PH_IDLE)
                      && ((i_tick.operation == OP_WRITE) || (i_tick.operation == OP_READ));

    assign a_phase         = start_op ? 6'd0 : r_phase;
    assign a_bit_count     = start_op ? BIT_FIRST : r_bit_count;
    assign n_held_device   = start_op ? i_tick.device_address : r_held_device;
    assign n_held_register = start_op ? i_tick.register_address : r_held_register;
    assign n_held_data     = start_op ? i_tick.write_data : r_held_data;
    assign n_is_read       = start_op ? (i_tick.operation == OP_READ) : r_is_read;

    assign seg      = a_phase[5:2];
    assign sub      = a_phase[1:0];
    assign nxt_seg  = 4'(seg + 4'd1);
    assign kind     = kind_of(seg, n_is_read);
    assign nxt_kind = kind_of(nxt_seg, n_is_read);

    // next state
    always_comb begin
        n_phase        = a_phase;
        n_bit_count    = a_bit_count;
        n_shift_byte   = r_shift_byte;
        n_settle_count = r_settle_count;
        n_last_read    = r_last_read;
        do_enter       = 1'b0;
        if (a_phase != PH_IDLE) begin
            unique case (kind)
                K_START: begin
                    if (sub == 2'd0) n_phase = 6'(a_phase + 6'd1);
                    else do_enter = 1'b1;
                end
                K_DEV, K_REG, K_DATA, K_DEVR: begin
                    if (sub == 2'd0) begin
                        n_phase = 6'(a_phase + 6'd1);
                    end else begin
                        n_shift_byte = {r_shift_byte[6:0], 1'b0};
                        if (a_bit_count == 3'd0) begin
                            do_enter = 1'b1;
                        end else begin
                            n_bit_count = 3'(a_bit_count - 3'd1);
                            n_phase     = {seg, 2'b00};
                        end
                    end
                end
                K_ACK: begin
                    if (sub == 2'd0) n_phase = 6'(a_phase + 6'd1);
                    else if (sub == 2'd1) begin
                        if (!i_tick.line_in) n_phase = 6'(a_phase + 6'd1);
                    end else do_enter = 1'b1;
                end
                K_READ: begin
                    if (sub == 2'd0) begin
                        n_shift_byte = {r_shift_byte[6:0], i_tick.line_in};
                        n_phase      = 6'(a_phase + 6'd1);
                    end else if (a_bit_count == 3'd0) begin
                        n_last_read = r_shift_byte;
                        do_enter    = 1'b1;
                    end else begin
                        n_bit_count = 3'(a_bit_count - 3'd1);
                        n_phase     = {seg, 2'b00};
                    end
                end
                K_NOACK: begin
                    if (sub == 2'd0) n_phase = 6'(a_phase + 6'd1);
                    else do_enter = 1'b1;
                end
                K_STOP: begin
                    if (sub != 2'd2 && sub != 2'd3) n_phase = 6'(a_phase + 6'd1);
                    else do_enter = 1'b1;
                end
                default: begin
                    if (r_settle_count == 16'd0) n_phase = PH_IDLE;
                    else n_settle_count = 16'(r_settle_count - 16'd1);
                end
            endcase
        end

        // move on to the next segment and preload what it needs
        if (do_enter) begin
            n_phase     = {nxt_seg, 2'b00};
            n_bit_count = BIT_FIRST;
            unique case (nxt_kind)
                K_DEV:    n_shift_byte = r_held_device;
                K_REG:    n_shift_byte = r_held_register;
                K_DATA:   n_shift_byte = r_held_data;
                K_DEVR:   n_shift_byte = r_held_device | 8'h01;
                K_READ:   n_shift_byte = 8'h00;
                K_SETTLE: n_settle_count = n_is_read ? 16'd0 : i_settle_ticks;
                default:  n_shift_byte = n_shift_byte;
            endcase
        end
    end

    // line levels and status for this tick
    always_comb begin
        o_result.clock_line = 1'b1;
        o_result.data_line  = 1'b1;
        o_result.busy_res   = 1'b0;
        o_result.done_res   = 1'b0;
        o_result.read_data  = n_last_read;
        if (a_phase != PH_IDLE) begin
            o_result.busy_res = 1'b1;
            unique case (kind)
                K_START: begin
                    o_result.data_line = (sub == 2'd0);
                end
                K_DEV, K_REG, K_DATA, K_DEVR: begin
                    o_result.data_line  = r_shift_byte[7];
                    o_result.clock_line = (sub != 2'd0);
                end
                K_ACK: begin
                    o_result.clock_line = (sub == 2'd1);
                end
                K_READ: begin
                    o_result.clock_line = (sub == 2'd0);
                end
                K_NOACK: begin
                    o_result.clock_line = (sub != 2'd0);
                end
                K_STOP: begin
                    o_result.clock_line = (sub != 2'd0);
                    o_result.data_line  = (sub != 2'd0) && (sub != 2'd1);
                end
                default: begin
                    if (r_settle_count == 16'd0) begin
                        o_result.busy_res = 1'b0;
                        o_result.done_res = 1'b1;
                    end
                end
            endcase
        end
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_bit_count     <= 3'd0;
            r_shift_byte    <= 8'h00;
            r_held_device   <= 8'h00;
            r_held_register <= 8'h00;
            r_held_data     <= 8'h00;
            r_is_read       <= 1'b0;
            r_settle_count  <= 16'd0;
            r_last_read     <= 8'h00;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_bit_count     <= n_bit_count;
            r_shift_byte    <= n_shift_byte;
            r_held_device   <= n_held_device;
            r_held_register <= n_held_register;
            r_held_data     <= n_held_data;
            r_is_read       <= n_is_read;
            r_settle_count  <= n_settle_count;
            r_last_read     <= n_last_read;
        end
    end

`ifndef SYNTH
    // sub-phase three is never used by any segment
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_phase[1:0] != 2'd3))
        else $error("phase reached unused sub-phase");

    // an item without a write or read operation while idle leaves the block idle
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_IDLE) && !start_op) |=> (r_phase == PH_IDLE))
        else $error("idle block left idle without an operation");

    // the done tick returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.done_res) |=> (r_phase == PH_IDLE))
        else $error("done tick did not return to idle");

    // a started transaction is busy on its first tick
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_op |-> (o_result.busy_res && !o_result.done_res))
        else $error("new transaction not busy on its first tick");
`endif

endmodule

>>> dv/i2c_register_access_master_tb.sv
`timescale 1ns / 1ps

module i2c_register_access_master_tb;
    import i2cram_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 10_000_000;
    localparam int         MAX_PRINTED = 100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_tick       tick_drv  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        clk_line;
    logic        dat_line;
    logic        busy_line;
    logic        done_line;
    logic [7:0]  rdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // line-level model state
    logic [5:0]  ph;
    logic [2:0]  bits_left;
    logic [7:0]  shreg;
    logic [7:0]  dev_q;
    logic [7:0]  reg_q;
    logic [7:0]  data_q;
    logic        rd_mode;
    logic [15:0] settle_cnt;
    logic [7:0]  rd_byte_q;
    logic [15:0] settle_cfg;

    t_result expected_lines[$];
    t_result want_line;

    int  mismatches      = 0;
    int  results_checked = 0;
    int  ticks_sent      = 0;
    int  writes_done     = 0;
    int  reads_done      = 0;
    int  cfg_writes      = 0;
    int  cycle_count     = 0;
    int  stall_left      = 0;
    int  ack_held        = 0;
    int  ack_patience    = 0;
    int  max_ack_wait    = 3;
    bit  quiet           = 1'b0;

    i2c_register_access_master u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_operation        (tick_drv.operation),
        .i_device_address   (tick_drv.device_address),
        .i_register_address (tick_drv.register_address),
        .i_write_data       (tick_drv.write_data),
        .i_line_in          (tick_drv.line_in),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_clock_line       (clk_line),
        .o_data_line        (dat_line),
        .o_busy_res         (busy_line),
        .o_done_res         (done_line),
        .o_read_data        (rdata),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // segment order of a register write and of a register read
    function automatic t_kind seg_kind(input logic [3:0] seg);
        t_kind k;
        k = K_SETTLE;
        if (rd_mode) begin
            case (seg)
                4'd0, 4'd5:  k = K_START;
                4'd1:        k = K_DEV;
                4'd2, 4'd4, 4'd7: k = K_ACK;
                4'd3:        k = K_REG;
                4'd6:        k = K_DEVR;
                4'd8:        k = K_READ;
                4'd9:        k = K_NOACK;
                4'd10:       k = K_STOP;
                default:     k = K_SETTLE;
            endcase
        end else begin
            case (seg)
                4'd0:        k = K_START;
                4'd1:        k = K_DEV;
                4'd2, 4'd4, 4'd6: k = K_ACK;
                4'd3:        k = K_REG;
                4'd5:        k = K_DATA;
                4'd7:        k = K_STOP;
                default:     k = K_SETTLE;
            endcase
        end
        return k;
    endfunction

    // move to the first sub-phase of a segment and load its byte or settle count
    function automatic void enter_seg(input logic [3:0] seg);
        t_kind k;
        k = seg_kind(seg);
        ph = {seg, 2'b00};
        bits_left = BIT_FIRST;
        case (k)
            K_DEV:    shreg = dev_q;
            K_REG:    shreg = reg_q;
            K_DATA:   shreg = data_q;
            K_DEVR:   shreg = dev_q | 8'h01;
            K_READ:   shreg = 8'h00;
            K_SETTLE: settle_cnt = rd_mode ? 16'd0 : settle_cfg;
            default:  ;
        endcase
    endfunction

    function automatic void reset_model();
        settle_cfg = SETTLE_RESET;
        ph         = PH_IDLE;
        bits_left  = '0;
        shreg      = '0;
        dev_q      = '0;
        reg_q      = '0;
        data_q     = '0;
        rd_mode    = 1'b0;
        settle_cnt = '0;
        rd_byte_q  = '0;
    endfunction

    // one tick: line levels and status that the block must produce
    function automatic t_result line_step(input t_tick t);
        t_result    r;
        logic [3:0] seg;
        logic [1:0] sub;
        t_kind      k;
        r.clock_line = 1'b1;
        r.data_line  = 1'b1;
        r.busy_res   = 1'b0;
        r.done_res   = 1'b0;
        if (ph == PH_IDLE && (t.operation == OP_WRITE || t.operation == OP_READ)) begin
            dev_q   = t.device_address;
            reg_q   = t.register_address;
            data_q  = t.write_data;
            rd_mode = (t.operation == OP_READ);
            enter_seg(4'd0);
        end
        if (ph != PH_IDLE) begin
            seg = ph[5:2];
            sub = ph[1:0];
            k = seg_kind(seg);
            r.busy_res = 1'b1;
            case (k)
                K_START: begin
                    if (sub == 2'd0) begin
                        ph = ph + 6'd1;
                    end else begin
                        r.data_line = 1'b0;
                        enter_seg(seg + 4'd1);
                    end
                end
                K_DEV, K_REG, K_DATA, K_DEVR: begin
                    r.data_line = shreg[7];
                    if (sub == 2'd0) begin
                        r.clock_line = 1'b0;
                        ph = ph + 6'd1;
                    end else begin
                        shreg = shreg << 1;
                        if (bits_left == 3'd0) begin
                            enter_seg(seg + 4'd1);
                        end else begin
                            bits_left = bits_left - 3'd1;
                            ph = {seg, 2'b00};
                        end
                    end
                end
                K_ACK: begin
                    if (sub == 2'd0) begin
                        r.clock_line = 1'b0;
                        ph = ph + 6'd1;
                    end else if (sub == 2'd1) begin
                        if (!t.line_in) ph = ph + 6'd1;
                    end else begin
                        r.clock_line = 1'b0;
                        enter_seg(seg + 4'd1);
                    end
                end
                K_READ: begin
                    if (sub == 2'd0) begin
                        shreg = {shreg[6:0], t.line_in};
                        ph = ph + 6'd1;
                    end else begin
                        r.clock_line = 1'b0;
                        if (bits_left == 3'd0) begin
                            rd_byte_q = shreg;
                            enter_seg(seg + 4'd1);
                        end else begin
                            bits_left = bits_left - 3'd1;
                            ph = {seg, 2'b00};
                        end
                    end
                end
                K_NOACK: begin
                    if (sub == 2'd0) begin
                        r.clock_line = 1'b0;
                        ph = ph + 6'd1;
                    end else begin
                        enter_seg(seg + 4'd1);
                    end
                end
                K_STOP: begin
                    if (sub == 2'd0) begin
                        r.clock_line = 1'b0;
                        r.data_line  = 1'b0;
                        ph = ph + 6'd1;
                    end else if (sub == 2'd1) begin
                        r.data_line = 1'b0;
                        ph = ph + 6'd1;
                    end else begin
                        enter_seg(seg + 4'd1);
                    end
                end
                default: begin
                    if (settle_cnt == 16'd0) begin
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                        ph = PH_IDLE;
                        if (rd_mode) reads_done++;
                        else writes_done++;
                    end else begin
                        settle_cnt = settle_cnt - 16'd1;
                    end
                end
            endcase
        end
        r.read_data = rd_byte_q;
        return r;
    endfunction

    // well-formed slave behavior: byte bits when read, acknowledge after a while
    function automatic logic line_for_tick(input logic [7:0] rd_val);
        t_kind k;
        k = seg_kind(ph[5:2]);
        if (k == K_READ && ph[1:0] == 2'd0) return rd_val[bits_left];
        if (k == K_ACK && ph[1:0] == 2'd1) begin
            if (ack_held < ack_patience) begin
                ack_held++;
                return 1'b1;
            end
            ack_held = 0;
            ack_patience = $urandom_range(0, max_ack_wait);
            return 1'b0;
        end
        return 1'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("ERROR: %s", msg);
    endtask

    // drive one tick, optionally after a random gap, and predict its result
    task automatic send_tick(input t_tick t);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick_drv <= t;
        do @(posedge clk); while (!in_ready);
        expected_lines.push_back(line_step(t));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_lines.size() != 0);
    endtask

    task automatic set_settle_ticks(input logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settle_cfg = value;
        cfg_writes++;
    endtask

    // one register access from start tick to done tick
    task automatic run_access(input logic [1:0] op, input logic [7:0] dev,
                              input logic [7:0] regad, input logic [7:0] wdata,
                              input logic [7:0] rd_val, input int noise_pct);
        t_tick t;
        t.operation        = op;
        t.device_address   = dev;
        t.register_address = regad;
        t.write_data       = wdata;
        t.line_in          = 1'($urandom);
        send_tick(t);
        while (ph != PH_IDLE) begin
            // an operation on the done tick must be ignored as well
            if (seg_kind(ph[5:2]) == K_SETTLE && settle_cnt == 16'd0)
                t.operation = 2'($urandom_range(1, 3));
            else
                t.operation = 2'($urandom_range(0, 3));
            t.device_address   = 8'($urandom);
            t.register_address = 8'($urandom);
            t.write_data       = 8'($urandom);
            if ($urandom_range(0, 99) < noise_pct) t.line_in = 1'($urandom);
            else t.line_in = line_for_tick(rd_val);
            send_tick(t);
        end
    endtask

    // first write after reset with a short settle delay
    task automatic test_first_write();
        set_settle_ticks(16'd5);
        run_access(OP_WRITE, 8'hFF, 8'h00, 8'hA5, 8'h00, 0);
    endtask

    task automatic test_read_extremes();
        run_access(OP_READ, 8'hFE, 8'hFF, 8'h00, 8'hFF, 0);
        run_access(OP_READ, 8'h01, 8'h80, 8'h7F, 8'h81, 0);
    endtask

    task automatic test_idle_codes();
        t_tick t;
        t.device_address   = 8'hFF;
        t.register_address = 8'h00;
        t.write_data       = 8'hFF;
        t.line_in          = 1'b0;
        t.operation = OP_TICK;
        send_tick(t);
        t.operation = OP_UNUSED;
        send_tick(t);
        t.line_in = 1'b1;
        send_tick(t);
        t.operation = OP_TICK;
        send_tick(t);
    endtask

    task automatic test_slow_acknowledge();
        max_ack_wait = 20;
        ack_patience = 20;
        ack_held = 0;
        run_access(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
        max_ack_wait = 3;
    endtask

    task automatic test_settle_extremes();
        set_settle_ticks(16'd0);
        run_access(OP_WRITE, 8'h00, 8'hFF, 8'h00, 8'h00, 0);
        set_settle_ticks(16'd20);
        run_access(OP_WRITE, 8'h5A, 8'hC3, 8'hFF, 8'h00, 0);
    endtask

    // mostly well-formed accesses with random content, some idle noise
    task automatic test_random_traffic(input logic [15:0] settle, input int budget);
        t_tick t;
        int    first;
        bit    paused;
        set_settle_ticks(settle);
        first = ticks_sent;
        paused = 1'b0;
        while (ticks_sent - first < budget) begin
            if (!paused && ticks_sent - first >= budget / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                t.operation        = $urandom_range(0, 1) ? OP_UNUSED : OP_TICK;
                t.device_address   = 8'($urandom);
                t.register_address = 8'($urandom);
                t.write_data       = 8'($urandom);
                t.line_in          = 1'($urandom);
                send_tick(t);
            end else begin
                run_access($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 15);
            end
        end
    endtask

    // result side: check each result and stall at random while not quiet
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (expected_lines.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_checked));
                end else begin
                    want_line = expected_lines.pop_front();
                    if (clk_line !== want_line.clock_line)
                        report_mismatch($sformatf("result %0d clock_line got %b expected %b",
                                        results_checked, clk_line, want_line.clock_line));
                    if (dat_line !== want_line.data_line)
                        report_mismatch($sformatf("result %0d data_line got %b expected %b",
                                        results_checked, dat_line, want_line.data_line));
                    if (busy_line !== want_line.busy_res)
                        report_mismatch($sformatf("result %0d busy_res got %b expected %b",
                                        results_checked, busy_line, want_line.busy_res));
                    if (done_line !== want_line.done_res)
                        report_mismatch($sformatf("result %0d done_res got %b expected %b",
                                        results_checked, done_line, want_line.done_res));
                    if (rdata !== want_line.read_data)
                        report_mismatch($sformatf("result %0d read_data got %h expected %h",
                                        results_checked, rdata, want_line.read_data));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 18);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // test sequence
    initial begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_write();
        test_read_extremes();
        test_idle_codes();
        test_slow_acknowledge();
        test_settle_extremes();
        test_random_traffic(16'd1, 40);
        quiet = 1'b1;
        test_random_traffic(16'($urandom_range(0, 4)), 30);

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_lines.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_lines.size()));

        $display("covered %0d register writes and %0d register reads in %0d ticks",
                 writes_done, reads_done, ticks_sent);
        $display("%0d results checked over %0d settle settings, %0d mismatches",
                 results_checked, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
